// ===== sv/sb_pkg.sv =====
// Package for the 512-bit GOST R 34.11-2012 hash block.
// Holds the S-box, the linear map rows, the round constants and the LPS function.
// Used by sb_datapath, sb_ctrl and streebog512_hash.
package sb_pkg;

   localparam int WORD_W = 64;
   localparam int WORDS = 8;
   localparam int STATE_W = WORD_W * WORDS;
   localparam int ROUNDS = 12;
   localparam int ROUND_W = 4;
   localparam int TAIL_W = 6;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_block;     // capture the message block and start a compression
      logic start_len;      // start the compression g_0(h, N)
      logic start_sum;      // start the compression g_0(h, Sigma)
      logic round;          // run one round
      logic finish;         // fold the result into the chain value
      logic clear;          // return h, N and Sigma to zero
      logic [ROUND_W-1:0] round_idx;
   } sb_cmd_type;

   typedef logic [7:0] sbox_arr_type [256];

   localparam sbox_arr_type SBOX = '{
      8'd252, 8'd238, 8'd221, 8'd17, 8'd207, 8'd110, 8'd49, 8'd22,
      8'd251, 8'd196, 8'd250, 8'd218, 8'd35, 8'd197, 8'd4, 8'd77,
      8'd233, 8'd119, 8'd240, 8'd219, 8'd147, 8'd46, 8'd153, 8'd186,
      8'd23, 8'd54, 8'd241, 8'd187, 8'd20, 8'd205, 8'd95, 8'd193,
      8'd249, 8'd24, 8'd101, 8'd90, 8'd226, 8'd92, 8'd239, 8'd33,
      8'd129, 8'd28, 8'd60, 8'd66, 8'd139, 8'd1, 8'd142, 8'd79,
      8'd5, 8'd132, 8'd2, 8'd174, 8'd227, 8'd106, 8'd143, 8'd160,
      8'd6, 8'd11, 8'd237, 8'd152, 8'd127, 8'd212, 8'd211, 8'd31,
      8'd235, 8'd52, 8'd44, 8'd81, 8'd234, 8'd200, 8'd72, 8'd171,
      8'd242, 8'd42, 8'd104, 8'd162, 8'd253, 8'd58, 8'd206, 8'd204,
      8'd181, 8'd112, 8'd14, 8'd86, 8'd8, 8'd12, 8'd118, 8'd18,
      8'd191, 8'd114, 8'd19, 8'd71, 8'd156, 8'd183, 8'd93, 8'd135,
      8'd21, 8'd161, 8'd150, 8'd41, 8'd16, 8'd123, 8'd154, 8'd199,
      8'd243, 8'd145, 8'd120, 8'd111, 8'd157, 8'd158, 8'd178, 8'd177,
      8'd50, 8'd117, 8'd25, 8'd61, 8'd255, 8'd53, 8'd138, 8'd126,
      8'd109, 8'd84, 8'd198, 8'd128, 8'd195, 8'd189, 8'd13, 8'd87,
      8'd223, 8'd245, 8'd36, 8'd169, 8'd62, 8'd168, 8'd67, 8'd201,
      8'd215, 8'd121, 8'd214, 8'd246, 8'd124, 8'd34, 8'd185, 8'd3,
      8'd224, 8'd15, 8'd236, 8'd222, 8'd122, 8'd148, 8'd176, 8'd188,
      8'd220, 8'd232, 8'd40, 8'd80, 8'd78, 8'd51, 8'd10, 8'd74,
      8'd167, 8'd151, 8'd96, 8'd115, 8'd30, 8'd0, 8'd98, 8'd68,
      8'd26, 8'd184, 8'd56, 8'd130, 8'd100, 8'd159, 8'd38, 8'd65,
      8'd173, 8'd69, 8'd70, 8'd146, 8'd39, 8'd94, 8'd85, 8'd47,
      8'd140, 8'd163, 8'd165, 8'd125, 8'd105, 8'd213, 8'd149, 8'd59,
      8'd7, 8'd88, 8'd179, 8'd64, 8'd134, 8'd172, 8'd29, 8'd247,
      8'd48, 8'd55, 8'd107, 8'd228, 8'd136, 8'd217, 8'd231, 8'd137,
      8'd225, 8'd27, 8'd131, 8'd73, 8'd76, 8'd63, 8'd248, 8'd254,
      8'd141, 8'd83, 8'd170, 8'd144, 8'd202, 8'd216, 8'd133, 8'd97,
      8'd32, 8'd113, 8'd103, 8'd164, 8'd45, 8'd43, 8'd9, 8'd91,
      8'd203, 8'd155, 8'd37, 8'd208, 8'd190, 8'd229, 8'd108, 8'd82,
      8'd89, 8'd166, 8'd116, 8'd210, 8'd230, 8'd244, 8'd180, 8'd192,
      8'd209, 8'd102, 8'd175, 8'd194, 8'd57, 8'd75, 8'd99, 8'd182
   };

   typedef logic [WORD_W-1:0] lin_arr_type [64];

   localparam lin_arr_type LIN_ROWS = '{
      64'h8e20faa72ba0b470, 64'h47107ddd9b505a38, 64'had08b0e0c3282d1c, 64'hd8045870ef14980e,
      64'h6c022c38f90a4c07, 64'h3601161cf205268d, 64'h1b8e0b0e798c13c8, 64'h83478b07b2468764,
      64'ha011d380818e8f40, 64'h5086e740ce47c920, 64'h2843fd2067adea10, 64'h14aff010bdd87508,
      64'h0ad97808d06cb404, 64'h05e23c0468365a02, 64'h8c711e02341b2d01, 64'h46b60f011a83988e,
      64'h90dab52a387ae76f, 64'h486dd4151c3dfdb9, 64'h24b86a840e90f0d2, 64'h125c354207487869,
      64'h092e94218d243cba, 64'h8a174a9ec8121e5d, 64'h4585254f64090fa0, 64'haccc9ca9328a8950,
      64'h9d4df05d5f661451, 64'hc0a878a0a1330aa6, 64'h60543c50de970553, 64'h302a1e286fc58ca7,
      64'h18150f14b9ec46dd, 64'h0c84890ad27623e0, 64'h0642ca05693b9f70, 64'h0321658cba93c138,
      64'h86275df09ce8aaa8, 64'h439da0784e745554, 64'hafc0503c273aa42a, 64'hd960281e9d1d5215,
      64'he230140fc0802984, 64'h71180a8960409a42, 64'hb60c05ca30204d21, 64'h5b068c651810a89e,
      64'h456c34887a3805b9, 64'hac361a443d1c8cd2, 64'h561b0d22900e4669, 64'h2b838811480723ba,
      64'h9bcf4486248d9f5d, 64'hc3e9224312c8c1a0, 64'heffa11af0964ee50, 64'hf97d86d98a327728,
      64'he4fa2054a80b329c, 64'h727d102a548b194e, 64'h39b008152acb8227, 64'h9258048415eb419d,
      64'h492c024284fbaec0, 64'haa16012142f35760, 64'h550b8e9e21f7a530, 64'ha48b474f9ef5dc18,
      64'h70a6a56e2440598e, 64'h3853dc371220a247, 64'h1ca76e95091051ad, 64'h0edd37c48a08a6d8,
      64'h07e095624504536c, 64'h8d70c431ac02a736, 64'hc83862965601dd1b, 64'h641c314b2b8ee083
   };

   typedef logic [STATE_W-1:0] rc_arr_type [ROUNDS];

   // Round constants, word 0 in the top bits.
   localparam rc_arr_type ROUND_CONST = '{
      {64'hb1085bda1ecadae9, 64'hebcb2f81c0657c1f, 64'h2f6a76432e45d016, 64'h714eb88d7585c4fc,
       64'h4b7ce09192676901, 64'ha2422a08a460d315, 64'h05767436cc744d23, 64'hdd806559f2a64507},
      {64'h6fa3b58aa99d2f1a, 64'h4fe39d460f70b5d7, 64'hf3feea720a232b98, 64'h61d55e0f16b50131,
       64'h9ab5176b12d69958, 64'h5cb561c2db0aa7ca, 64'h55dda21bd7cbcd56, 64'he679047021b19bb7},
      {64'hf574dcac2bce2fc7, 64'h0a39fc286a3d8435, 64'h06f15e5f529c1f8b, 64'hf2ea7514b1297b7b,
       64'hd3e20fe490359eb1, 64'hc1c93a376062db09, 64'hc2b6f443867adb31, 64'h991e96f50aba0ab2},
      {64'hef1fdfb3e81566d2, 64'hf948e1a05d71e4dd, 64'h488e857e335c3c7d, 64'h9d721cad685e353f,
       64'ha9d72c82ed03d675, 64'hd8b71333935203be, 64'h3453eaa193e837f1, 64'h220cbebc84e3d12e},
      {64'h4bea6bacad474799, 64'h9a3f410c6ca92363, 64'h7f151c1f1686104a, 64'h359e35d7800fffbd,
       64'hbfcd1747253af5a3, 64'hdfff00b723271a16, 64'h7a56a27ea9ea63f5, 64'h601758fd7c6cfe57},
      {64'hae4faeae1d3ad3d9, 64'h6fa4c33b7a3039c0, 64'h2d66c4f95142a46c, 64'h187f9ab49af08ec6,
       64'hcffaa6b71c9ab7b4, 64'h0af21f66c2bec6b6, 64'hbf71c57236904f35, 64'hfa68407a46647d6e},
      {64'hf4c70e16eeaac5ec, 64'h51ac86febf240954, 64'h399ec6c7e6bf87c9, 64'hd3473e33197a93c9,
       64'h0992abc52d822c37, 64'h06476983284a0504, 64'h3517454ca23c4af3, 64'h8886564d3a14d493},
      {64'h9b1f5b424d93c9a7, 64'h03e7aa020c6e4141, 64'h4eb7f8719c36de1e, 64'h89b4443b4ddbc49a,
       64'hf4892bcb929b0690, 64'h69d18d2bd1a5c42f, 64'h36acc2355951a8d9, 64'ha47f0dd4bf02e71e},
      {64'h378f5a541631229b, 64'h944c9ad8ec165fde, 64'h3a7d3a1b25894224, 64'h3cd955b7e00d0984,
       64'h800a440bdbb2ceb1, 64'h7b2b8a9aa6079c54, 64'h0e38dc92cb1f2a60, 64'h7261445183235adb},
      {64'habbedea680056f52, 64'h382ae548b2e4f3f3, 64'h8941e71cff8a78db, 64'h1fffe18a1b336103,
       64'h9fe76702af69334b, 64'h7a1e6c303b7652f4, 64'h3698fad1153bb6c3, 64'h74b4c7fb98459ced},
      {64'h7bcd9ed0efc889fb, 64'h3002c6cd635afe94, 64'hd8fa6bbbebab0761, 64'h2001802114846679,
       64'h8a1d71efea48b9ca, 64'hefbacd1d7d476e98, 64'hdea2594ac06fd85d, 64'h6bcaa4cd81f32d1b},
      {64'h378ee767f11631ba, 64'hd21380b00449b17a, 64'hcda43c32bcdf1d77, 64'hf82012d430219f9b,
       64'h5d80ef9d1891cc86, 64'he71da4aa88e12852, 64'hfaf417d5d9b21b99, 64'h48bc924af11bd720}
   };

   // One LPS transform over a 512-bit value, word 0 in the top bits.
   function automatic logic [STATE_W-1:0] lps(input logic [STATE_W-1:0] v);
      logic [STATE_W-1:0] res;
      logic [WORD_W-1:0] t;
      logic [WORD_W-1:0] acc;
      logic [7:0] b;
      res = '0;
      for (int i = 0; i < WORDS; i++) begin
         t = '0;
         for (int j = 0; j < WORDS; j++) begin
            b = v[STATE_W - 1 - WORD_W*j - 8*i -: 8];
            t[WORD_W - 1 - 8*j -: 8] = SBOX[b];
         end
         acc = '0;
         for (int k = 0; k < 64; k++) begin
            if (t[63 - k]) begin
               acc = acc ^ LIN_ROWS[k];
            end
         end
         res[STATE_W - 1 - WORD_W*i -: WORD_W] = acc;
      end
      return res;
   endfunction

endpackage

// ===== sv/sb_datapath.sv =====
// Datapath of the hash block: chain value, length counter, checksum and the
// shared round unit (one LPS on the state and one on the key per cycle).
// Depends on sb_pkg.
module sb_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  sb_pkg::sb_cmd_type              cmd,
   input  logic [sb_pkg::STATE_W-1:0]      blk_data,
   input  logic                            blk_final,
   input  logic [sb_pkg::TAIL_W-1:0]       blk_tail,
   output logic [sb_pkg::STATE_W-1:0]      digest
);

   logic [sb_pkg::STATE_W-1:0] h_ff, n_ff, sig_ff;
   logic [sb_pkg::STATE_W-1:0] st_ff, st_in;
   logic [sb_pkg::STATE_W-1:0] key_ff, key_in;
   logic [sb_pkg::STATE_W-1:0] msg_ff;
   logic [sb_pkg::STATE_W-1:0] padded;
   logic [sb_pkg::STATE_W-1:0] len_add;
   logic [sb_pkg::STATE_W-1:0] keep_mask;
   logic [sb_pkg::STATE_W-1:0] h_upd;
   logic [sb_pkg::STATE_W-1:0] lps_st, lps_key;
   logic [9:0] nbits;

   // Tail bytes are kept, a 0x01 byte goes directly above them.
   assign nbits = {1'b0, blk_tail, 3'b000};
   assign keep_mask = ~({sb_pkg::STATE_W{1'b1}} << nbits);
   assign padded = blk_final
      ? ((blk_data & keep_mask) | ({{(sb_pkg::STATE_W-1){1'b0}}, 1'b1} << nbits))
      : blk_data;
   assign len_add = blk_final
      ? {{(sb_pkg::STATE_W-10){1'b0}}, nbits}
      : {{(sb_pkg::STATE_W-10){1'b0}}, 10'h200};

   assign lps_st  = sb_pkg::lps(st_ff ^ key_ff);
   assign lps_key = sb_pkg::lps(key_ff ^ sb_pkg::ROUND_CONST[cmd.round_idx]);
   assign h_upd   = h_ff ^ st_ff ^ key_ff ^ msg_ff;

   // The follow-on compressions start in the fold cycle, so their key comes
   // from the chain value that is being written in that same cycle.
   always_comb begin
      st_in  = st_ff;
      key_in = key_ff;
      if (cmd.load_block) begin
         st_in  = padded;
         key_in = sb_pkg::lps(h_ff ^ n_ff);
      end else if (cmd.start_len) begin
         st_in  = n_ff;
         key_in = sb_pkg::lps(h_upd);
      end else if (cmd.start_sum) begin
         st_in  = sig_ff;
         key_in = sb_pkg::lps(h_upd);
      end else if (cmd.round) begin
         st_in  = lps_st;
         key_in = lps_key;
      end
   end

   always_ff @(posedge clock) begin
      st_ff  <= st_in;
      key_ff <= key_in;
      if (cmd.load_block) begin
         msg_ff <= padded;
      end else if (cmd.start_len) begin
         msg_ff <= n_ff;
      end else if (cmd.start_sum) begin
         msg_ff <= sig_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         h_ff   <= '0;
         n_ff   <= '0;
         sig_ff <= '0;
      end else begin
         if (cmd.finish) begin
            h_ff <= h_upd;
         end
         if (cmd.load_block) begin
            n_ff   <= n_ff + len_add;
            sig_ff <= sig_ff + padded;
         end
      end
   end

   assign digest = h_ff;

endmodule

// ===== sv/sb_ctrl.sv =====
// Controller of the hash block: sequences the rounds of up to three
// compressions per item and runs the input and output handshakes.
// Depends on sb_pkg.
module sb_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic                 in_final,
   output logic                 in_ready,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic                 out_load,
   output sb_pkg::sb_cmd_type   cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROUND,
      ST_FOLD,
      ST_WAIT
   } state_type;

   typedef enum logic [1:0] {
      PH_MSG,
      PH_LEN,
      PH_SUM
   } phase_type;

   state_type state_ff;
   phase_type phase_ff;
   logic final_ff;
   logic [sb_pkg::ROUND_W-1:0] rnd_ff;
   logic out_valid_ff;

   assign in_ready  = (state_ff == ST_IDLE);
   assign out_valid = out_valid_ff;

   always_comb begin
      cmd = '0;
      cmd.round_idx = rnd_ff;
      cmd.load_block = in_valid && in_ready;
      cmd.round = (state_ff == ST_ROUND);
      cmd.finish = (state_ff == ST_FOLD);
      cmd.start_len = (state_ff == ST_FOLD) && final_ff && (phase_ff == PH_MSG);
      cmd.start_sum = (state_ff == ST_FOLD) && final_ff && (phase_ff == PH_LEN);
      cmd.clear = out_valid_ff && out_ready;
   end

   // Marks the final fold of the chain value; the top level captures the digest after it.
   assign out_load = (state_ff == ST_FOLD) && (phase_ff == PH_SUM);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_MSG;
         final_ff     <= 1'b0;
         rnd_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (in_valid) begin
                  state_ff <= ST_ROUND;
                  phase_ff <= PH_MSG;
                  final_ff <= in_final;
                  rnd_ff   <= '0;
               end
            end
            ST_ROUND: begin
               if (rnd_ff == sb_pkg::ROUNDS[sb_pkg::ROUND_W-1:0] - 1'b1) begin
                  rnd_ff   <= '0;
                  state_ff <= ST_FOLD;
               end else begin
                  rnd_ff <= rnd_ff + 1'b1;
               end
            end
            ST_FOLD: begin
               rnd_ff <= '0;
               case (phase_ff)
                  PH_MSG: begin
                     if (final_ff) begin
                        phase_ff <= PH_LEN;
                        state_ff <= ST_ROUND;
                     end else begin
                        state_ff <= ST_IDLE;
                     end
                  end
                  PH_LEN: begin
                     phase_ff <= PH_SUM;
                     state_ff <= ST_ROUND;
                  end
                  default: begin
                     state_ff     <= ST_WAIT;
                     out_valid_ff <= 1'b1;
                  end
               endcase
            end
            ST_WAIT: begin
               if (out_ready) begin
                  out_valid_ff <= 1'b0;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

`ifndef SYNTHESIS
   a_result_only_in_wait: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (state_ff == ST_WAIT))
      else $error("result shown outside the wait state");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !cmd.load_block)
      else $error("block loaded while busy");
   a_round_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND) |-> (rnd_ff < sb_pkg::ROUNDS[sb_pkg::ROUND_W-1:0]))
      else $error("round counter out of range");
   a_fold_after_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FOLD) |-> $past(state_ff == ST_ROUND))
      else $error("fold without rounds");
`endif

endmodule

// ===== sv/streebog512_hash.sv =====
// Top level of the 512-bit GOST R 34.11-2012 hash block.
// Instantiates sb_ctrl and sb_datapath; depends on sb_pkg.
//
// Channel | Direction | Content
// req_    | in        | one 512-bit message block, final flag and tail length
// rsp_    | out       | the 512-bit digest after a final block
//
// A non-final block runs load, twelve rounds, then the fold into the chain value.
// A final block runs three compressions (message, length, checksum), then waits for rsp_tready.
// The round unit is shared by the three compressions.
// Reset is synchronous and clears chain value, length and checksum.
// While a digest waits, no new block is taken; the state is cleared on its transfer.
module streebog512_hash (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // tdata: block_word_7 [63:0] up to block_word_0 [511:448], tail_bytes [517:512]
   input  logic [519:0]  req_tdata,
   input  logic          req_tlast,    // final_block
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // tdata: digest_word_7 [63:0] up to digest_word_0 [511:448]
   output logic [511:0]  rsp_tdata
);

   sb_pkg::sb_cmd_type cmd;
   logic out_load;

   sb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_final  (req_tlast),
      .in_ready  (req_tready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_load  (out_load),
      .cmd       (cmd)
   );

   logic [sb_pkg::STATE_W-1:0] digest;
   logic [sb_pkg::STATE_W-1:0] rsp_ff;

   sb_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .blk_data  (req_tdata[sb_pkg::STATE_W-1:0]),
      .blk_final (req_tlast),
      .blk_tail  (req_tdata[sb_pkg::STATE_W +: sb_pkg::TAIL_W]),
      .digest    (digest)
   );

   // The final fold updates the chain value in the same cycle, so capture
   // the digest in the cycle after it.
   logic cap_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= 1'b0;
      end else begin
         cap_ff <= out_load;
      end
   end

   always_ff @(posedge clock) begin
      if (cap_ff) begin
         rsp_ff <= digest;
      end
   end

   assign rsp_tdata = cap_ff ? digest : rsp_ff;

endmodule
